// File: rtl/mvm_pkg.sv
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared widths, codes and types of the multiset value matcher.
// ----------------------------------------------------------------------------
package mvm_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int AMOUNT_BITS = 40;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // port widths
  localparam int MODE_W      = 2;
  localparam int IN_AMT_W    = 40;
  localparam int STATUS_W    = 2;
  localparam int OUT_IDX_W   = 6;

  // request modes
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MATCH  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_REPORT = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_MATCH  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NONE_LEFT = 2'd3;

  typedef logic [AMOUNT_BITS-1:0] amount_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  // search token that steps along the cell row
  typedef struct packed {
    logic    valid;
    logic    report;
    amount_t key;
  } probe_t;

  // event raised by a cell when the token stops or finds an entry
  typedef struct packed {
    logic hit;
    logic fin;
    idx_t idx;
  } ev_t;

  // clear and write broadcast to all cells
  typedef struct packed {
    logic    clr;
    logic    wr;
    idx_t    wr_idx;
    amount_t wr_amt;
  } bcast_t;

endpackage

// File: rtl/mvm_cell.sv
// ----------------------------------------------------------------------------
// mvm_cell
// One table entry: stored amount, claimed mark, and one stage of the token row.
// ----------------------------------------------------------------------------
module mvm_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  mvm_pkg::idx_t   cell_idx,
  input  mvm_pkg::cnt_t   count,
  input  mvm_pkg::bcast_t bc,
  input  mvm_pkg::probe_t probe_in,
  output mvm_pkg::probe_t probe_out,
  output mvm_pkg::ev_t    ev
);

  mvm_pkg::amount_t amt_r;
  mvm_pkg::amount_t amt_nxt;
  logic             claimed_r;
  logic             claimed_nxt;
  mvm_pkg::probe_t  probe_r;
  mvm_pkg::probe_t  probe_nxt;
  mvm_pkg::ev_t     ev_r;
  mvm_pkg::ev_t     ev_nxt;

  logic occupied;
  logic free;
  logic eq;
  logic claim;

  // entry state seen by the token
  assign occupied = mvm_pkg::CNT_W'(cell_idx) < count;
  assign free     = occupied && !claimed_r;
  assign eq       = amt_r == probe_in.key;
  assign claim    = probe_in.valid && !probe_in.report && free && eq;

  // entry clear and write, then token handling: claim and stop, report and pass, or stop at first unloaded cell
  always_comb begin
    amt_nxt     = amt_r;
    claimed_nxt = claimed_r;
    probe_nxt   = probe_in;
    ev_nxt      = '0;
    if (bc.clr) begin
      claimed_nxt = 1'b0;
    end
    if (bc.wr && bc.wr_idx == cell_idx) begin
      amt_nxt     = bc.wr_amt;
      claimed_nxt = 1'b0;
    end
    if (claim) begin
      claimed_nxt = 1'b1;
    end
    if (probe_in.valid) begin
      if (!occupied) begin
        ev_nxt.fin      = 1'b1;
        probe_nxt.valid = 1'b0;
      end else if (claim) begin
        ev_nxt.hit      = 1'b1;
        ev_nxt.idx      = cell_idx;
        probe_nxt.valid = 1'b0;
      end else if (probe_in.report && free) begin
        ev_nxt.hit = 1'b1;
        ev_nxt.idx = cell_idx;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    amt_r <= amt_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      claimed_r <= 1'b0;
      probe_r   <= '0;
      ev_r      <= '0;
    end else begin
      claimed_r <= claimed_nxt;
      probe_r   <= probe_nxt;
      ev_r      <= ev_nxt;
    end
  end

  assign probe_out = probe_r;
  assign ev        = ev_r;

endmodule

// File: rtl/mvm_ctrl.sv
// ----------------------------------------------------------------------------
// mvm_ctrl
// Request decode, entry count, token launch and result sequencing.
// ----------------------------------------------------------------------------
module mvm_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [mvm_pkg::MODE_W-1:0]      in_mode,
  input  logic [mvm_pkg::IN_AMT_W-1:0]    in_amount,
  input  mvm_pkg::ev_t                    ev,
  input  logic                            tail,
  output mvm_pkg::probe_t                 launch,
  output mvm_pkg::bcast_t                 bc,
  output mvm_pkg::cnt_t                   count,
  output logic                            out_valid,
  output logic [mvm_pkg::STATUS_W-1:0]    out_status,
  output logic [mvm_pkg::OUT_IDX_W-1:0]   out_entry_index,
  output logic                            out_last
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  logic                          state_r, state_nxt;
  mvm_pkg::cnt_t                 count_r, count_nxt;
  mvm_pkg::probe_t               launch_r, launch_nxt;
  logic                          report_r, report_nxt;
  logic                          pend_v_r, pend_v_nxt;
  mvm_pkg::idx_t                 pend_idx_r, pend_idx_nxt;
  logic                          tail_r;
  logic                          valid_r, valid_nxt;
  logic [mvm_pkg::STATUS_W-1:0]  status_r, status_nxt;
  mvm_pkg::idx_t                 index_r, index_nxt;
  logic                          last_r, last_nxt;

  logic accept;
  logic fin;

  assign busy   = state_r == S_WALK;
  assign accept = start && !busy;
  assign fin    = ev.fin || tail_r;

  // request decode and result sequencing
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    launch_nxt   = launch_r;
    report_nxt   = report_r;
    pend_v_nxt   = pend_v_r;
    pend_idx_nxt = pend_idx_r;
    valid_nxt    = 1'b0;
    status_nxt   = mvm_pkg::ST_OK;
    index_nxt    = '0;
    last_nxt     = 1'b1;
    bc           = '0;
    bc.wr_idx    = mvm_pkg::IDX_W'(count_r);
    bc.wr_amt    = mvm_pkg::AMOUNT_BITS'(in_amount);
    launch_nxt.valid = 1'b0;
    if (accept) begin
      case (in_mode)
        mvm_pkg::MODE_CLEAR: begin
          bc.clr    = 1'b1;
          count_nxt = '0;
          valid_nxt = 1'b1;
        end
        mvm_pkg::MODE_LOAD: begin
          valid_nxt = 1'b1;
          if (count_r == mvm_pkg::CNT_W'(mvm_pkg::TABLE_DEPTH)) begin
            status_nxt = mvm_pkg::ST_FULL;
          end else begin
            bc.wr     = 1'b1;
            index_nxt = mvm_pkg::IDX_W'(count_r);
            count_nxt = count_r + 1'b1;
          end
        end
        default: begin
          state_nxt         = S_WALK;
          report_nxt        = in_mode == mvm_pkg::MODE_REPORT;
          pend_v_nxt        = 1'b0;
          launch_nxt.valid  = 1'b1;
          launch_nxt.report = in_mode == mvm_pkg::MODE_REPORT;
          launch_nxt.key    = mvm_pkg::AMOUNT_BITS'(in_amount);
        end
      endcase
    end else if (state_r == S_WALK) begin
      if (!report_r) begin
        // match search: first hit or end of table
        if (ev.hit) begin
          valid_nxt = 1'b1;
          index_nxt = ev.idx;
          state_nxt = S_IDLE;
        end else if (fin) begin
          valid_nxt  = 1'b1;
          status_nxt = mvm_pkg::ST_NO_MATCH;
          state_nxt  = S_IDLE;
        end
      end else begin
        // report walk: hold one found entry back so the final one carries last
        if (ev.hit) begin
          pend_v_nxt   = 1'b1;
          pend_idx_nxt = ev.idx;
          if (pend_v_r) begin
            valid_nxt = 1'b1;
            index_nxt = pend_idx_r;
            last_nxt  = 1'b0;
          end
        end else if (fin) begin
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
          if (pend_v_r) begin
            index_nxt = pend_idx_r;
          end else begin
            status_nxt = mvm_pkg::ST_NONE_LEFT;
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    status_r   <= status_nxt;
    index_r    <= index_nxt;
    last_r     <= last_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      launch_r <= '0;
      report_r <= 1'b0;
      pend_v_r <= 1'b0;
      tail_r   <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      launch_r <= launch_nxt;
      report_r <= report_nxt;
      pend_v_r <= pend_v_nxt;
      tail_r   <= tail;
      valid_r  <= valid_nxt;
    end
  end

  assign launch          = launch_r;
  assign count           = count_r;
  assign out_valid       = valid_r;
  assign out_status      = status_r;
  assign out_entry_index = mvm_pkg::OUT_IDX_W'(index_r);
  assign out_last        = last_r;

endmodule

// File: rtl/multiset_value_matcher_top.sv
// ----------------------------------------------------------------------------
// multiset_value_matcher_top
// Table of target amounts with claimed marks, matched one to one by value.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Clear and load give
// their single result in the cycle after the transfer and never raise busy,
// so they can be issued every cycle. Match and report launch a search token
// into a row of TABLE_DEPTH cells that steps one cell per cycle: a match holds
// busy until the token claims an entry or passes the last loaded entry (a miss),
// and a report holds busy until the token passes that entry, giving at most
// one result per cycle. Results appear on out_* for one cycle with out_valid
// high and cannot be stalled; the receiver must take every transfer.
// ----------------------------------------------------------------------------
module multiset_value_matcher_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [mvm_pkg::MODE_W-1:0]      in_mode,
  input  logic [mvm_pkg::IN_AMT_W-1:0]    in_amount,
  output logic                            out_valid,
  output logic [mvm_pkg::STATUS_W-1:0]    out_status,
  output logic [mvm_pkg::OUT_IDX_W-1:0]   out_entry_index,
  output logic                            out_last
);

  mvm_pkg::probe_t chain [mvm_pkg::TABLE_DEPTH+1];
  mvm_pkg::ev_t    cev   [mvm_pkg::TABLE_DEPTH];
  mvm_pkg::ev_t    ev_all;
  mvm_pkg::bcast_t bc;
  mvm_pkg::cnt_t   count;
  mvm_pkg::probe_t launch;

  // controller
  mvm_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_amount       (in_amount),
    .ev              (ev_all),
    .tail            (chain[mvm_pkg::TABLE_DEPTH].valid),
    .launch          (launch),
    .bc              (bc),
    .count           (count),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_entry_index (out_entry_index),
    .out_last        (out_last)
  );

  assign chain[0] = launch;

  // row of cells, token passes from each cell to the next
  for (genvar i = 0; i < mvm_pkg::TABLE_DEPTH; i++) begin : g_cell
    mvm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (mvm_pkg::IDX_W'(i)),
      .count     (count),
      .bc        (bc),
      .probe_in  (chain[i]),
      .probe_out (chain[i+1]),
      .ev        (cev[i])
    );
  end

  // at most one cell raises an event per cycle, so the events merge by or
  always_comb begin
    ev_all = '0;
    for (int i = 0; i < mvm_pkg::TABLE_DEPTH; i++) begin
      ev_all.hit = ev_all.hit | cev[i].hit;
      ev_all.fin = ev_all.fin | cev[i].fin;
      ev_all.idx = ev_all.idx | cev[i].idx;
    end
  end

endmodule
